[hdl/assert_macros.svh]
// Assertion macros shared by the sampler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hdl/cics_pkg.sv]
// Package for the categorical inverse CDF sampler: sizes, command codes
// and the command and result payload types. No dependencies.
`timescale 1ns / 1ps

package cics_pkg;

  // Table geometry.
  localparam int NumCategories = 64;
  localparam int WeightBits    = 16;
  localparam int IdxW          = $clog2(NumCategories);
  localparam int CntW          = $clog2(NumCategories + 1);
  localparam int TotW          = WeightBits + IdxW;

  // Fixed point formats.
  localparam int LevelW   = 17;
  localparam int ProbW    = 17;
  localparam int FracBits = 16;
  localparam int ProdW    = LevelW + TotW;
  localparam int DivCntW  = $clog2(ProbW);
  localparam logic [ProbW-1:0] OneQ16 = ProbW'(1 << FracBits);

  // Configuration register.
  localparam int CfgW   = 7;
  localparam int CmpW   = (CntW > CfgW) ? CntW : CfgW;
  localparam int KReset = (NumCategories < 64) ? NumCategories : 64;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_QUANTILE = 2'd1,
    CMD_PDF      = 2'd2,
    CMD_CDF      = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic signed [7:0]  category_index;
    logic        [15:0] weight_value;
    logic        [16:0] level;
  } item_t;

  typedef struct packed {
    logic [5:0]  chosen_category;
    logic [16:0] probability;
    logic        status;
  } result_t;

endpackage

[hdl/categorical_inverse_cdf_sampler_top.sv]
// Categorical inverse CDF sampler: weight table, running total, table walk
// and radix-2 divider under one sequencer. Depends on cics_pkg and assert_macros.svh.
//
// A command transfers when start is high and busy is low; its single result
// shows on result_o for one cycle with result_valid_o, and busy falls in that
// same cycle, so a new command may follow at once. The receiver cannot stall.
// The result of an in-range write is registered after the S_WUPD state; an
// out-of-range write, and every query at zero total, out-of-range index,
// saturated cdf, or a quantile with one category in use, is answered from idle.
// A quantile query multiplies once, then walks one table entry per cycle
// through the single read port of the weight memory until the hit or the
// last category in use. A pdf query reads its entry and a cdf query at index
// i walks entries 0 to i, each then followed by the 17-step restoring divider.
// A write to the categories register clears the weights above the new count
// and then rebuilds the total in a pass over all entries, during which busy
// is high; register writes are taken at any time and drop a command in flight.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module categorical_inverse_cdf_sampler_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cics_pkg::item_t  item_i,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_wdata_i,
  output logic             result_valid_o,
  output cics_pkg::result_t result_o
);
  import cics_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WUPD,
    S_MUL,
    S_PDATA,
    S_WALK,
    S_DIV,
    S_SUM
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         k_q, k_d;
  logic [TotW-1:0]         total_q, total_d;
  logic [NumCategories-1:0] vld_q, vld_d;
  cmd_e                    cmd_q, cmd_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [WeightBits-1:0]   wv_q, wv_d;
  logic [LevelW-1:0]       lvl_q, lvl_d;
  logic [ProdW-1:0]        target_q, target_d;
  logic [TotW-1:0]         prefix_q, prefix_d;
  logic [CntW-1:0]         iss_q, iss_d;
  logic [IdxW-1:0]         proc_q, proc_d;
  logic                    pend_q, pend_d;
  logic [IdxW-1:0]         last_q, last_d;
  logic [TotW:0]           rem_q, rem_d;
  logic [ProbW-1:0]        quo_q, quo_d;
  logic [DivCntW-1:0]      dcnt_q, dcnt_d;
  result_t                 res_q, res_d;
  logic                    rvalid_q, rvalid_d;

  // Weight memory with one registered read port.
  logic [WeightBits-1:0]   mem [NumCategories];
  logic [IdxW-1:0]         rd_addr;
  logic [WeightBits-1:0]   rd_data_q;
  logic                    rd_vbit_q;
  logic                    mem_we;

  // Datapath helpers.
  logic [WeightBits-1:0]   eff_w;
  logic [TotW-1:0]         psum;
  logic                    hit;
  logic                    issue;
  logic                    div_ge;
  logic [TotW:0]           div_sub;
  logic [ProbW-1:0]        quo_next;
  logic                    start_ok;
  logic                    idx_neg;
  logic [CmpW-1:0]         idx_mag;
  logic [CmpW-1:0]         k_ext;
  logic                    in_range;
  logic                    at_end;
  logic [LevelW-1:0]       lvl_sat;
  logic [CmpW-1:0]         cfg_ext;
  logic [CntW-1:0]         k_new;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rvalid_q;
  assign result_o       = res_q;

  // An entry that was never written since reset reads as zero.
  assign eff_w = rd_vbit_q ? rd_data_q : '0;
  assign psum  = prefix_q + TotW'(eff_w);
  assign hit   = ProdW'({psum, {FracBits{1'b0}}}) >= target_q;
  assign issue = ((state_q == S_WALK) || (state_q == S_SUM)) && (iss_q <= CntW'(last_q));

  // One restoring division step against the total.
  assign div_ge   = rem_q >= (TotW + 1)'(total_q);
  assign div_sub  = div_ge ? (rem_q - (TotW + 1)'(total_q)) : rem_q;
  assign quo_next = {quo_q[ProbW-2:0], div_ge};

  // Command decode.
  assign start_ok = start && (state_q == S_IDLE);
  assign idx_neg  = item_i.category_index[7];
  assign idx_mag  = CmpW'(item_i.category_index[6:0]);
  assign k_ext    = CmpW'(k_q);
  assign in_range = !idx_neg && (idx_mag < k_ext);
  assign at_end   = !idx_neg && (({1'b0, idx_mag} + 1'b1) >= {1'b0, k_ext});
  assign lvl_sat  = (item_i.level > OneQ16) ? OneQ16 : item_i.level;

  // Register value clamped to the table size, never below one.
  assign cfg_ext = CmpW'(cfg_wdata_i);
  always_comb begin
    if (cfg_ext == '0) begin
      k_new = CntW'(1);
    end else if (cfg_ext > CmpW'(NumCategories)) begin
      k_new = CntW'(NumCategories);
    end else begin
      k_new = CntW'(cfg_ext);
    end
  end

  assign rd_addr = (state_q == S_IDLE) ? item_i.category_index[IdxW-1:0] : iss_q[IdxW-1:0];

  // Sequencer next state and datapath.
  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    total_d  = total_q;
    vld_d    = vld_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    wv_d     = wv_q;
    lvl_d    = lvl_q;
    target_d = target_q;
    prefix_d = prefix_q;
    iss_d    = iss_q;
    proc_d   = proc_q;
    pend_d   = 1'b0;
    last_d   = last_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    res_d    = res_q;
    rvalid_d = 1'b0;
    mem_we   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_ok) begin
          cmd_d = item_i.command;
          res_d = '0;
          priority if (item_i.command == CMD_WRITE) begin
            if (in_range) begin
              idx_d   = item_i.category_index[IdxW-1:0];
              wv_d    = item_i.weight_value[WeightBits-1:0];
              state_d = S_WUPD;
            end else begin
              rvalid_d = 1'b1;
            end
          end else if (total_q == '0) begin
            res_d.status = 1'b1;
            rvalid_d     = 1'b1;
          end else if (item_i.command == CMD_QUANTILE) begin
            if (k_q == CntW'(1)) begin
              rvalid_d = 1'b1;
            end else begin
              lvl_d   = lvl_sat;
              last_d  = IdxW'(k_q - CntW'(2));
              state_d = S_MUL;
            end
          end else if (item_i.command == CMD_PDF) begin
            if (in_range) begin
              state_d = S_PDATA;
            end else begin
              rvalid_d = 1'b1;
            end
          end else begin
            if (idx_neg) begin
              rvalid_d = 1'b1;
            end else if (at_end) begin
              res_d.probability = OneQ16;
              rvalid_d          = 1'b1;
            end else begin
              last_d   = item_i.category_index[IdxW-1:0];
              iss_d    = '0;
              prefix_d = '0;
              state_d  = S_WALK;
            end
          end
        end
      end

      // Old weight is on the read port now; swap it out of the total.
      S_WUPD: begin
        total_d       = total_q - TotW'(eff_w) + TotW'(wv_q);
        mem_we        = 1'b1;
        vld_d[idx_q]  = 1'b1;
        rvalid_d      = 1'b1;
        state_d       = S_IDLE;
      end

      S_MUL: begin
        target_d = ProdW'(lvl_q) * ProdW'(total_q);
        iss_d    = '0;
        prefix_d = '0;
        state_d  = S_WALK;
      end

      S_PDATA: begin
        rem_d   = (TotW + 1)'(eff_w);
        quo_d   = '0;
        dcnt_d  = DivCntW'(ProbW - 1);
        state_d = S_DIV;
      end

      // Walk the table one entry per cycle; each read is issued in the cycle before its entry is used.
      S_WALK: begin
        if (issue) begin
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
          proc_d = iss_q[IdxW-1:0];
        end
        if (pend_q) begin
          prefix_d = psum;
          if (cmd_q == CMD_QUANTILE) begin
            if (hit) begin
              res_d.chosen_category = 6'(proc_q);
              rvalid_d              = 1'b1;
              pend_d                = 1'b0;
              state_d               = S_IDLE;
            end else if (proc_q == last_q) begin
              res_d.chosen_category = 6'(k_q - CntW'(1));
              rvalid_d              = 1'b1;
              pend_d                = 1'b0;
              state_d               = S_IDLE;
            end
          end else if (proc_q == last_q) begin
            rem_d   = (TotW + 1)'(psum);
            quo_d   = '0;
            dcnt_d  = DivCntW'(ProbW - 1);
            pend_d  = 1'b0;
            state_d = S_DIV;
          end
        end
      end

      // Rebuild the total after the active count changed.
      S_SUM: begin
        if (issue) begin
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
          proc_d = iss_q[IdxW-1:0];
        end
        if (pend_q) begin
          prefix_d = psum;
          if (proc_q == last_q) begin
            total_d = psum;
            pend_d  = 1'b0;
            state_d = S_IDLE;
          end
        end
      end

      S_DIV: begin
        quo_d  = quo_next;
        rem_d  = {div_sub[TotW-1:0], 1'b0};
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          res_d.probability = quo_next;
          rvalid_d          = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Register write: drop weights above the new count, then re-sum.
    if (cfg_we_i) begin
      k_d = k_new;
      for (int i = 0; i < NumCategories; i++) begin
        if (CntW'(i) >= k_new) begin
          vld_d[i] = 1'b0;
        end
      end
      iss_d    = '0;
      pend_d   = 1'b0;
      prefix_d = '0;
      last_d   = IdxW'(NumCategories - 1);
      state_d  = S_SUM;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= CntW'(KReset);
      total_q  <= '0;
      vld_q    <= '0;
      cmd_q    <= CMD_WRITE;
      idx_q    <= '0;
      wv_q     <= '0;
      lvl_q    <= '0;
      target_q <= '0;
      prefix_q <= '0;
      iss_q    <= '0;
      proc_q   <= '0;
      pend_q   <= 1'b0;
      last_q   <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      dcnt_q   <= '0;
      res_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      total_q  <= total_d;
      vld_q    <= vld_d;
      cmd_q    <= cmd_d;
      idx_q    <= idx_d;
      wv_q     <= wv_d;
      lvl_q    <= lvl_d;
      target_q <= target_d;
      prefix_q <= prefix_d;
      iss_q    <= iss_d;
      proc_q   <= proc_d;
      pend_q   <= pend_d;
      last_q   <= last_d;
      rem_q    <= rem_d;
      quo_q    <= quo_d;
      dcnt_q   <= dcnt_d;
      res_q    <= res_d;
      rvalid_q <= rvalid_d;
    end
  end

  // Weight memory write port and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q] <= wv_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  // The valid bit travels with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vbit_q <= 1'b0;
    end else begin
      rd_vbit_q <= vld_q[rd_addr];
    end
  end

  // Checks on the sequencer.
  `ASSERT_CLK(a_div_ends_in_result, clk_i, rst_ni, (state_q == S_DIV && dcnt_q == '0 && !cfg_we_i) |=> rvalid_q, "divider finished without a result")
  `ASSERT_CLK(a_prob_bounded, clk_i, rst_ni, rvalid_q |-> (res_q.probability <= OneQ16), "probability above one")
  `ASSERT_CLK(a_pend_in_walk, clk_i, rst_ni, pend_q |-> (state_q == S_WALK || state_q == S_SUM), "table read pending outside a walk")
  `ASSERT_CLK(a_status_zero_total, clk_i, rst_ni, (rvalid_q && res_q.status) |-> (total_q == '0 && res_q.probability == '0), "error status with nonzero total")

endmodule
